// File: hdl/cfba_pkg.sv
// Package for the chained free block allocator: sizes, result and status codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
package cfba_pkg;

  localparam int CACHE_DEPTH      = 32;
  localparam int ADDR_W           = $clog2(CACHE_DEPTH);
  localparam int CNT_W            = $clog2(CACHE_DEPTH + 1);
  localparam int RIDX_W           = $clog2(CACHE_DEPTH + 2);
  localparam int BLK_W            = 16;
  localparam int FIRST_DATA_BLOCK = 2;

  // request codes
  localparam logic [1:0] REQ_FREE   = 2'd0;
  localparam logic [1:0] REQ_ALLOC  = 2'd1;
  localparam logic [1:0] REQ_REFILL = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_GRANT  = 3'd0;
  localparam logic [2:0] KIND_FREED  = 3'd1;
  localparam logic [2:0] KIND_SPILL  = 3'd2;
  localparam logic [2:0] KIND_REFILL = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // result status
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_INVALID    = 3'd1;
  localparam logic [2:0] STAT_NOSPACE    = 3'd2;
  localparam logic [2:0] STAT_BUSY       = 3'd3;
  localparam logic [2:0] STAT_BADCOUNT   = 3'd4;
  localparam logic [2:0] STAT_READERR    = 3'd5;
  localparam logic [2:0] STAT_UNEXPECTED = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_SPILL
  } state_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_PUSH,
    DP_SPILL_START,
    DP_SPILL_STEP,
    DP_POP_RD,
    DP_GRANT_POP,
    DP_REFILL_REQ,
    DP_RESTORE,
    DP_SET_EXP,
    DP_REFILL_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       res_en;
    logic [2:0] kind;
    logic [2:0] status;
    logic       last;
  } cfba_cmd_t;

  typedef struct packed {
    logic awaiting;
    logic blk_invalid;
    logic full;
    logic cnt_bad;
    logic idx_zero;
    logic word_bad;
    logic refill_done;
    logic top_zero;
    logic rd_zero;
    logic spill_last;
  } cfba_sts_t;

endpackage

// File: hdl/cfba_ctrl.sv
// Controller for the chained free block allocator: decodes requests, sequences
// pops and spills, and issues datapath commands. Depends on cfba_pkg.
module cfba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         req_type,
  input  logic               fill_error,
  input  cfba_pkg::cfba_sts_t sts,
  output cfba_pkg::cfba_cmd_t cmd,
  output logic               busy
);
  import cfba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && !sts.awaiting) begin
          if (req_type == REQ_FREE && !sts.blk_invalid && sts.full) begin
            state_nxt = S_SPILL;
          end else if (req_type == REQ_ALLOC && !sts.cnt_bad) begin
            state_nxt = S_ALLOC;
          end
        end
      end
      S_ALLOC: state_nxt = S_IDLE;
      S_SPILL: begin
        if (sts.spill_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '{op: DP_NONE, res_en: 1'b0, kind: KIND_ERROR, status: STAT_OK, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_FREE: begin
              cmd.res_en = 1'b1;
              if (sts.awaiting) begin
                cmd.status = STAT_BUSY;
              end else if (sts.blk_invalid) begin
                cmd.status = STAT_INVALID;
              end else if (sts.full) begin
                cmd.op   = DP_SPILL_START;
                cmd.kind = KIND_SPILL;
                cmd.last = 1'b0;
              end else begin
                cmd.op   = DP_PUSH;
                cmd.kind = KIND_FREED;
              end
            end
            REQ_ALLOC: begin
              if (sts.awaiting) begin
                cmd.res_en = 1'b1;
                cmd.status = STAT_BUSY;
              end else if (sts.cnt_bad) begin
                cmd.res_en = 1'b1;
                cmd.status = STAT_NOSPACE;
              end else begin
                cmd.op = DP_POP_RD;
              end
            end
            REQ_REFILL: begin
              if (!sts.awaiting) begin
                cmd.res_en = 1'b1;
                cmd.status = STAT_UNEXPECTED;
              end else if (fill_error) begin
                cmd.op     = DP_RESTORE;
                cmd.res_en = 1'b1;
                cmd.status = STAT_READERR;
              end else if (sts.idx_zero) begin
                if (sts.word_bad) begin
                  cmd.op     = DP_RESTORE;
                  cmd.res_en = 1'b1;
                  cmd.status = STAT_BADCOUNT;
                end else begin
                  cmd.op = DP_SET_EXP;
                end
              end else begin
                cmd.op     = DP_REFILL_WR;
                cmd.res_en = sts.refill_done;
                cmd.kind   = KIND_GRANT;
              end
            end
            default: cmd.op = DP_NONE;
          endcase
        end
      end
      S_ALLOC: begin
        cmd.res_en = 1'b1;
        if (sts.top_zero && sts.rd_zero) begin
          cmd.status = STAT_NOSPACE;
        end else if (sts.top_zero) begin
          cmd.op   = DP_REFILL_REQ;
          cmd.kind = KIND_REFILL;
        end else begin
          cmd.op   = DP_GRANT_POP;
          cmd.kind = KIND_GRANT;
        end
      end
      S_SPILL: begin
        cmd.op     = DP_SPILL_STEP;
        cmd.res_en = 1'b1;
        cmd.kind   = KIND_SPILL;
        cmd.last   = sts.spill_last;
      end
      default: cmd.op = DP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hdl/cfba_dpath.sv
// Datapath for the chained free block allocator: free stack memory, counters,
// refill bookkeeping, the total_blocks register and the result registers. Depends on cfba_pkg.
module cfba_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfba_pkg::cfba_cmd_t          cmd,
  output cfba_pkg::cfba_sts_t          sts,
  input  logic [cfba_pkg::BLK_W-1:0]   block_number,
  input  logic [cfba_pkg::BLK_W-1:0]   fill_word,
  input  logic                         cfg_we,
  input  logic [cfba_pkg::BLK_W-1:0]   cfg_data,
  output logic                         out_valid,
  output logic [2:0]                   out_kind,
  output logic [cfba_pkg::BLK_W-1:0]   out_block_out,
  output logic [cfba_pkg::BLK_W-1:0]   out_spill_word,
  output logic [2:0]                   out_status,
  output logic                         out_last
);
  import cfba_pkg::*;

  logic [BLK_W-1:0]  mem [CACHE_DEPTH];
  logic              e0_vld_r;
  logic [BLK_W-1:0]  rd_q_r;

  logic [BLK_W-1:0]  total_blocks_r;
  logic [CNT_W-1:0]  stack_count_r, stack_count_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [BLK_W-1:0]  chain_r, chain_nxt;
  logic [CNT_W-1:0]  refill_exp_r, refill_exp_nxt;
  logic [RIDX_W-1:0] refill_idx_r, refill_idx_nxt;
  logic [BLK_W-1:0]  spill_blk_r, spill_blk_nxt;
  logic [ADDR_W-1:0] spill_idx_r, spill_idx_nxt;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [BLK_W-1:0]  wr_data;
  logic [CNT_W-1:0]  count_m1;
  logic [RIDX_W-1:0] ridx_m1;
  logic [BLK_W-1:0]  res_block, res_word;

  logic              out_valid_r;
  logic [2:0]        out_kind_r, out_status_r;
  logic [BLK_W-1:0]  out_block_r, out_word_r;
  logic              out_last_r;

  assign count_m1 = stack_count_r - CNT_W'(1);
  assign ridx_m1  = refill_idx_r - RIDX_W'(1);

  // status towards the controller
  always_comb begin
    sts.awaiting    = awaiting_r;
    sts.blk_invalid = (block_number < BLK_W'(FIRST_DATA_BLOCK)) ||
                      (block_number >= total_blocks_r);
    sts.full        = (stack_count_r >= CNT_W'(CACHE_DEPTH));
    sts.cnt_bad     = (stack_count_r == '0) || (stack_count_r > CNT_W'(CACHE_DEPTH));
    sts.idx_zero    = (refill_idx_r == '0);
    sts.word_bad    = (fill_word == '0) || (fill_word > BLK_W'(CACHE_DEPTH));
    sts.refill_done = (refill_idx_r >= RIDX_W'(refill_exp_r));
    sts.top_zero    = (stack_count_r == CNT_W'(1));
    sts.rd_zero     = (rd_q_r == '0);
    sts.spill_last  = (spill_idx_r == ADDR_W'(CACHE_DEPTH - 1));
  end

  // memory ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = block_number;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (cmd.op)
      DP_PUSH: begin
        wr_en   = 1'b1;
        wr_addr = stack_count_r[ADDR_W-1:0];
      end
      DP_SPILL_START: rd_en = 1'b1;
      DP_SPILL_STEP: begin
        rd_en   = !sts.spill_last;
        rd_addr = spill_idx_r + ADDR_W'(1);
        wr_en   = sts.spill_last;
        wr_data = spill_blk_r;
      end
      DP_POP_RD: begin
        rd_en   = 1'b1;
        rd_addr = count_m1[ADDR_W-1:0];
      end
      DP_RESTORE: begin
        wr_en   = 1'b1;
        wr_data = chain_r;
      end
      DP_REFILL_WR: begin
        wr_en   = 1'b1;
        wr_addr = ridx_m1[ADDR_W-1:0];
        wr_data = fill_word;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // entry zero reads as zero until first written
      rd_q_r <= (rd_addr == '0 && !e0_vld_r) ? '0 : mem[rd_addr];
    end
  end

  // stack and refill bookkeeping
  always_comb begin
    stack_count_nxt = stack_count_r;
    awaiting_nxt    = awaiting_r;
    chain_nxt       = chain_r;
    refill_exp_nxt  = refill_exp_r;
    refill_idx_nxt  = refill_idx_r;
    spill_blk_nxt   = spill_blk_r;
    spill_idx_nxt   = spill_idx_r;
    case (cmd.op)
      DP_PUSH: stack_count_nxt = stack_count_r + CNT_W'(1);
      DP_SPILL_START: begin
        spill_blk_nxt = block_number;
        spill_idx_nxt = '0;
      end
      DP_SPILL_STEP: begin
        spill_idx_nxt = spill_idx_r + ADDR_W'(1);
        if (sts.spill_last) begin
          stack_count_nxt = CNT_W'(1);
        end
      end
      DP_GRANT_POP: stack_count_nxt = count_m1;
      DP_REFILL_REQ: begin
        stack_count_nxt = '0;
        awaiting_nxt    = 1'b1;
        chain_nxt       = rd_q_r;
        refill_exp_nxt  = '0;
        refill_idx_nxt  = '0;
      end
      DP_RESTORE: begin
        stack_count_nxt = CNT_W'(1);
        awaiting_nxt    = 1'b0;
        refill_exp_nxt  = '0;
        refill_idx_nxt  = '0;
      end
      DP_SET_EXP: begin
        refill_exp_nxt = fill_word[CNT_W-1:0];
        refill_idx_nxt = RIDX_W'(1);
      end
      DP_REFILL_WR: begin
        refill_idx_nxt = refill_idx_r + RIDX_W'(1);
        if (sts.refill_done) begin
          stack_count_nxt = refill_exp_r;
          awaiting_nxt    = 1'b0;
          refill_exp_nxt  = '0;
          refill_idx_nxt  = '0;
        end
      end
      default: stack_count_nxt = stack_count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= '1;
      stack_count_r  <= CNT_W'(1);
      awaiting_r     <= 1'b0;
      chain_r        <= '0;
      refill_exp_r   <= '0;
      refill_idx_r   <= '0;
      e0_vld_r       <= 1'b0;
      spill_idx_r    <= '0;
    end else begin
      if (cfg_we) begin
        total_blocks_r <= cfg_data;
      end
      stack_count_r <= stack_count_nxt;
      awaiting_r    <= awaiting_nxt;
      chain_r       <= chain_nxt;
      refill_exp_r  <= refill_exp_nxt;
      refill_idx_r  <= refill_idx_nxt;
      spill_idx_r   <= spill_idx_nxt;
      if (wr_en && wr_addr == '0) begin
        e0_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    spill_blk_r <= spill_blk_nxt;
  end

  // result payload
  always_comb begin
    res_block = '0;
    res_word  = '0;
    case (cmd.op)
      DP_PUSH: res_block = block_number;
      DP_SPILL_START: begin
        res_block = block_number;
        res_word  = BLK_W'(CACHE_DEPTH);
      end
      DP_SPILL_STEP: begin
        res_block = spill_blk_r;
        res_word  = rd_q_r;
      end
      DP_GRANT_POP, DP_REFILL_REQ: res_block = rd_q_r;
      DP_REFILL_WR: res_block = chain_r;
      default: res_block = '0;
    endcase
    if (cmd.kind == KIND_ERROR) begin
      res_block = '0;
      res_word  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.res_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      out_kind_r   <= cmd.kind;
      out_status_r <= cmd.status;
      out_last_r   <= cmd.last;
      out_block_r  <= res_block;
      out_word_r   <= res_word;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_block_out  = out_block_r;
  assign out_spill_word = out_word_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule

// File: hdl/chained_free_block_allocator.sv
// Chained free block allocator, top level. Free: decided in IDLE, result the next cycle.
// Allocate: one registered read of the stack memory in IDLE, then ALLOC registers the result.
// Free onto a full stack: the SPILL state runs, and the spill words leave one per cycle from the
// memory read port. Refill words: taken in IDLE, one per transfer. Results strobe out_valid for one cycle and
// cannot be stalled. Synchronous active-low reset: stack holds one zero entry, no refill
// pending, total_blocks = 65535. No clearing pass.
module chained_free_block_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_req_type,
  input  logic [cfba_pkg::BLK_W-1:0] in_block_number,
  input  logic [cfba_pkg::BLK_W-1:0] in_fill_word,
  input  logic                       in_fill_error,
  // result channel, no back-pressure
  output logic                       out_valid,
  output logic [2:0]                 out_kind,
  output logic [cfba_pkg::BLK_W-1:0] out_block_out,
  output logic [cfba_pkg::BLK_W-1:0] out_spill_word,
  output logic [2:0]                 out_status,
  output logic                       out_last,
  // total_blocks write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cfba_pkg::BLK_W-1:0] cfg_total_blocks
);
  import cfba_pkg::*;

  cfba_cmd_t cmd;
  cfba_sts_t sts;
  logic      busy_w;

  // The controller only looks at start in IDLE, so a request transfer is
  // start && !busy. It decides every request against the datapath status of
  // the same cycle; the datapath carries out the command on that edge.
  cfba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .req_type   (in_req_type),
    .fill_error (in_fill_error),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy_w)
  );

  // Datapath: free stack memory, counters, refill state and result registers.
  // A write to total_blocks is always taken; the user must write it only while idle (not enforced).
  cfba_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .block_number   (in_block_number),
    .fill_word      (in_fill_word),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_total_blocks),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_block_out  (out_block_out),
    .out_spill_word (out_spill_word),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  assign busy      = busy_w;
  assign cfg_ready = 1'b1;

endmodule

// File: hdl/cfba_chk.sv
// Port-level checks for the chained free block allocator, bound to the top level.
// Depends on cfba_pkg.
module cfba_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_req_type,
  input logic                       out_valid,
  input logic [2:0]                 out_kind,
  input logic [2:0]                 out_status,
  input logic                       out_last
);
  import cfba_pkg::*;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last)
    else $error("error result without last");

  a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERROR |-> out_status == STAT_OK)
    else $error("non-error result with non-zero status");

  a_free_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == REQ_FREE |=> out_valid)
    else $error("free transfer gave no result next cycle");

  a_spill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SPILL && !out_last |-> busy)
    else $error("spill in progress but not busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

bind chained_free_block_allocator cfba_chk u_cfba_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid),
  .out_kind    (out_kind),
  .out_status  (out_status),
  .out_last    (out_last)
);
